>>> rtl/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared codes and fixed sizes of the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   localparam int OUT_DEPTH    = 2;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

endpackage

`default_nettype wire

>>> rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer Bresenham line rasterizer, all octants, at most one pixel per word.
//
//   channel   handshake          payload
//   request   push / full        req_op, req_x_start, req_y_start,
//                                req_x_end, req_y_end
//   result    empty / pop        rsp_pixel_x, rsp_pixel_y, rsp_last
//
// One word per cycle sustained while the back does not stall; each step is one add
// and compare in the back. An accepted request is registered in the command queue,
// then taken by the back and registered in the result buffer, from which it pops.
// full rises when the 4-entry command queue holds 4 words.
// The back stalls while its 2-entry result buffer is full and pop is low.
// Reset clears the queue, the result buffer and the line-active flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   output      logic                         full,
   input  wire logic                         req_op,
   input  wire logic signed [COORD_BITS-1:0] req_x_start,
   input  wire logic signed [COORD_BITS-1:0] req_y_start,
   input  wire logic signed [COORD_BITS-1:0] req_x_end,
   input  wire logic signed [COORD_BITS-1:0] req_y_end,
   output      logic                         empty,
   input  wire logic                         pop,
   output      logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output      logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output      logic                         rsp_last
);
   import brl_pkg::*;

   localparam int CMD_BITS = 6 * COORD_BITS + 5;

   logic                q_wr;
   logic [CMD_BITS-1:0] q_wr_data;
   logic                q_rd;
   logic [CMD_BITS-1:0] q_rd_data;
   logic                q_full;
   logic                q_empty;

   brl_front #(
      .COORD_BITS (COORD_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_front (
      .push        (push),
      .full        (full),
      .req_op      (req_op),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .q_full      (q_full),
      .q_wr        (q_wr),
      .q_wr_data   (q_wr_data)
   );

   brl_cmd_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (q_wr_data),
      .rd_en   (q_rd),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   brl_back #(
      .COORD_BITS (COORD_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_rd_data   (q_rd_data),
      .q_empty     (q_empty),
      .q_rd        (q_rd),
      .empty       (empty),
      .pop         (pop),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

>>> rtl/brl_front.sv
// ----------------------------------------------------------------------------
// brl_front
// Accepts request words and classifies them: deltas, major axis, endpoint
// order and single-point detection for a start, packed into a command word.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_front #(
   parameter int COORD_BITS = 11,
   parameter int CMD_BITS   = 6 * COORD_BITS + 5
) (
   input  wire logic                         push,
   output      logic                         full,
   input  wire logic                         req_op,
   input  wire logic signed [COORD_BITS-1:0] req_x_start,
   input  wire logic signed [COORD_BITS-1:0] req_y_start,
   input  wire logic signed [COORD_BITS-1:0] req_x_end,
   input  wire logic signed [COORD_BITS-1:0] req_y_end,
   input  wire logic                         q_full,
   output      logic                         q_wr,
   output      logic [CMD_BITS-1:0]          q_wr_data
);
   import brl_pkg::*;

   localparam int C = COORD_BITS;

   typedef struct packed {
      logic         op;
      logic         major_is_y;
      logic         last;
      logic [C-1:0] cur_x;
      logic [C-1:0] cur_y;
      logic [C-1:0] major_end;
      logic [C-1:0] minor_end;
      logic [C:0]   major_delta;
      logic [C:0]   minor_delta;
   } cmd_type;

   logic [C:0] diff_x;
   logic [C:0] diff_y;
   logic [C:0] abs_x;
   logic [C:0] abs_y;
   logic       x_major;
   logic       swap;
   cmd_type    cmd;

   assign diff_x  = {req_x_end[C-1], req_x_end} - {req_x_start[C-1], req_x_start};
   assign diff_y  = {req_y_end[C-1], req_y_end} - {req_y_start[C-1], req_y_start};
   assign abs_x   = diff_x[C] ? ((C+1)'(0) - diff_x) : diff_x;
   assign abs_y   = diff_y[C] ? ((C+1)'(0) - diff_y) : diff_y;
   assign x_major = (abs_x >= abs_y);
   assign swap    = x_major ? diff_x[C] : diff_y[C];

   always_comb begin
      cmd.op          = req_op;
      cmd.major_is_y  = !x_major;
      cmd.last        = (abs_x == '0) && (abs_y == '0);
      cmd.cur_x       = swap ? req_x_end : req_x_start;
      cmd.cur_y       = swap ? req_y_end : req_y_start;
      if (x_major) begin
         cmd.major_end   = swap ? req_x_start : req_x_end;
         cmd.minor_end   = swap ? req_y_start : req_y_end;
         cmd.major_delta = abs_x;
         cmd.minor_delta = abs_y;
      end else begin
         cmd.major_end   = swap ? req_y_start : req_y_end;
         cmd.minor_end   = swap ? req_x_start : req_x_end;
         cmd.major_delta = abs_y;
         cmd.minor_delta = abs_x;
      end
   end

   assign full      = q_full;
   assign q_wr      = push && !q_full;
   assign q_wr_data = cmd;

endmodule

`default_nettype wire

>>> rtl/brl_cmd_queue.sv
// ----------------------------------------------------------------------------
// brl_cmd_queue
// Short command queue between front and back; head word is read directly.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_cmd_queue #(
   parameter int WIDTH = 71
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   output      logic [WIDTH-1:0] rd_data,
   output      logic             full,
   output      logic             empty
);
   import brl_pkg::*;

   logic [WIDTH-1:0]      mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff;
   logic [Q_PTR_BITS-1:0] wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff;
   logic [Q_PTR_BITS-1:0] rd_ptr_in;
   logic [Q_CNT_BITS-1:0] cnt_ff;
   logic [Q_CNT_BITS-1:0] cnt_in;

   assign full    = (cnt_ff == Q_CNT_BITS'(Q_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + Q_CNT_BITS'(wr_en) - Q_CNT_BITS'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_BITS'(Q_DEPTH))
      else $error("queue count overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("queue read while empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("queue write while full");

endmodule

`default_nettype wire

>>> rtl/brl_back.sv
// ----------------------------------------------------------------------------
// brl_back
// Executes commands: loads a line on start, advances one pixel per step while a
// line is active, and buffers result words for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_back #(
   parameter int COORD_BITS = 11,
   parameter int CMD_BITS   = 6 * COORD_BITS + 5
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [CMD_BITS-1:0]          q_rd_data,
   input  wire logic                         q_empty,
   output      logic                         q_rd,
   output      logic                         empty,
   input  wire logic                         pop,
   output      logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output      logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output      logic                         rsp_last
);
   import brl_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int DEC = COORD_BITS + 3;

   typedef struct packed {
      logic         op;
      logic         major_is_y;
      logic         last;
      logic [C-1:0] cur_x;
      logic [C-1:0] cur_y;
      logic [C-1:0] major_end;
      logic [C-1:0] minor_end;
      logic [C:0]   major_delta;
      logic [C:0]   minor_delta;
   } cmd_type;

   cmd_type cmd;

   logic           active_ff;
   logic           active_in;
   logic           major_is_y_ff;
   logic           major_is_y_in;
   logic [C-1:0]   cur_x_ff;
   logic [C-1:0]   cur_x_in;
   logic [C-1:0]   cur_y_ff;
   logic [C-1:0]   cur_y_in;
   logic [C-1:0]   major_end_ff;
   logic [C-1:0]   major_end_in;
   logic [C-1:0]   minor_end_ff;
   logic [C-1:0]   minor_end_in;
   logic [DEC-1:0] decision_ff;
   logic [DEC-1:0] decision_in;
   logic [C:0]     major_delta_ff;
   logic [C:0]     major_delta_in;
   logic [C:0]     minor_delta_ff;
   logic [C:0]     minor_delta_in;

   logic [C-1:0]   out_x_ff [OUT_DEPTH];
   logic [C-1:0]   out_y_ff [OUT_DEPTH];
   logic           out_last_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] out_wp_ff;
   logic [OUT_PTR_BITS-1:0] out_wp_in;
   logic [OUT_PTR_BITS-1:0] out_rp_ff;
   logic [OUT_PTR_BITS-1:0] out_rp_in;
   logic [OUT_CNT_BITS-1:0] out_cnt_ff;
   logic [OUT_CNT_BITS-1:0] out_cnt_in;

   logic           take;
   logic           pop_ok;
   logic           out_room;
   logic           out_wr;
   logic [C-1:0]   out_x;
   logic [C-1:0]   out_y;
   logic           out_last;

   logic [C-1:0]   maj;
   logic [C-1:0]   mnr;
   logic [C-1:0]   maj_inc;
   logic [C-1:0]   mnr_mv;
   logic [C-1:0]   mnr_nxt;
   logic           dec_neg;
   logic [DEC-1:0] two_minor;
   logic [DEC-1:0] two_major;
   logic [DEC-1:0] dec_step;
   logic [DEC-1:0] dec_start;
   logic           step_last;

   assign cmd      = q_rd_data;
   assign pop_ok   = pop && !empty;
   assign out_room = (out_cnt_ff != OUT_CNT_BITS'(OUT_DEPTH)) || pop;
   assign take     = !q_empty && out_room;
   assign q_rd     = take;

   assign maj       = major_is_y_ff ? cur_y_ff : cur_x_ff;
   assign mnr       = major_is_y_ff ? cur_x_ff : cur_y_ff;
   assign maj_inc   = maj + C'(1);
   assign mnr_mv    = ($signed(mnr) < $signed(minor_end_ff)) ? mnr + C'(1) : mnr - C'(1);
   assign dec_neg   = decision_ff[DEC-1];
   assign mnr_nxt   = dec_neg ? mnr : mnr_mv;
   assign two_minor = {1'b0, minor_delta_ff, 1'b0};
   assign two_major = {1'b0, major_delta_ff, 1'b0};
   assign dec_step  = dec_neg ? decision_ff + two_minor
                              : decision_ff + two_minor - two_major;
   assign dec_start = {1'b0, cmd.minor_delta, 1'b0} - {2'b00, cmd.major_delta};
   assign step_last = (maj_inc == major_end_ff);

   always_comb begin
      active_in      = active_ff;
      major_is_y_in  = major_is_y_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      major_end_in   = major_end_ff;
      minor_end_in   = minor_end_ff;
      decision_in    = decision_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      out_wr         = 1'b0;
      out_x          = cur_x_ff;
      out_y          = cur_y_ff;
      out_last       = 1'b0;
      if (take) begin
         case (cmd.op)
            OP_START: begin
               active_in      = !cmd.last;
               major_is_y_in  = cmd.major_is_y;
               cur_x_in       = cmd.cur_x;
               cur_y_in       = cmd.cur_y;
               major_end_in   = cmd.major_end;
               minor_end_in   = cmd.minor_end;
               decision_in    = dec_start;
               major_delta_in = cmd.major_delta;
               minor_delta_in = cmd.minor_delta;
               out_wr         = 1'b1;
               out_x          = cmd.cur_x;
               out_y          = cmd.cur_y;
               out_last       = cmd.last;
            end
            OP_STEP: begin
               if (active_ff) begin
                  active_in   = !step_last;
                  cur_x_in    = major_is_y_ff ? mnr_nxt : maj_inc;
                  cur_y_in    = major_is_y_ff ? maj_inc : mnr_nxt;
                  decision_in = dec_step;
                  out_wr      = 1'b1;
                  out_x       = cur_x_in;
                  out_y       = cur_y_in;
                  out_last    = step_last;
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_comb begin
      out_wp_in  = out_wr ? out_wp_ff + 1'b1 : out_wp_ff;
      out_rp_in  = pop_ok ? out_rp_ff + 1'b1 : out_rp_ff;
      out_cnt_in = out_cnt_ff + OUT_CNT_BITS'(out_wr) - OUT_CNT_BITS'(pop_ok);
   end

   assign empty       = (out_cnt_ff == '0);
   assign rsp_pixel_x = out_x_ff[out_rp_ff];
   assign rsp_pixel_y = out_y_ff[out_rp_ff];
   assign rsp_last    = out_last_ff[out_rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         out_wp_ff  <= '0;
         out_rp_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         active_ff  <= active_in;
         out_wp_ff  <= out_wp_in;
         out_rp_ff  <= out_rp_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      major_is_y_ff  <= major_is_y_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      major_end_ff   <= major_end_in;
      minor_end_ff   <= minor_end_in;
      decision_ff    <= decision_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      if (out_wr) begin
         out_x_ff[out_wp_ff]    <= out_x;
         out_y_ff[out_wp_ff]    <= out_y;
         out_last_ff[out_wp_ff] <= out_last;
      end
   end

   a_active_not_at_end: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (maj != major_end_ff))
      else $error("active line already at its end");

   a_start_loads_active: assert property (@(posedge clock) disable iff (reset)
      (take && (cmd.op == OP_START)) |=> (active_ff == !$past(cmd.last)))
      else $error("start did not set active");

   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OUT_CNT_BITS'(OUT_DEPTH))
      else $error("result buffer overflow");

   a_out_wr_needs_take: assert property (@(posedge clock) disable iff (reset)
      out_wr |-> take)
      else $error("result written without a command");

endmodule

`default_nettype wire

>>> bench/bresenham_line_rasterizer_test.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_test
// Self-checking bench for the line rasterizer. Start and step words go in
// through the request queue. Every pixel that comes out is compared with a
// cycle-free predictor of the Bresenham walk, which runs on each accepted
// word. It runs directed corner lines first, then random lines that walk to
// their end, stop early or overrun, mixed with random noise words. Sender
// and receiver stall at random in the first two phases and never in the third.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import brl_pkg::*;

   localparam int COORD_BITS = 11;
   localparam int LINE_WORDS = 1950;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   class pixel_scoreboard;
      logic                    active;
      logic                    y_major;
      coord_type               cur_x;
      coord_type               cur_y;
      coord_type               major_end;
      coord_type               minor_end;
      logic signed [14:0]      decision;
      logic [11:0]             minor_delta;
      logic [11:0]             major_delta;
      pixel_type               pending[$];
      int                      errors;

      function new();
         active      = 1'b0;
         y_major     = 1'b0;
         cur_x       = '0;
         cur_y       = '0;
         major_end   = '0;
         minor_end   = '0;
         decision    = '0;
         minor_delta = '0;
         major_delta = '0;
         errors      = 0;
      endfunction

      function bit note_request(logic op, coord_type xs, coord_type ys, coord_type xe,
                                coord_type ye);
         int        ax, ay, bx, by, dx, dy, mj, mn, d;
         bit        fin;
         pixel_type px;
         if (op == OP_START) begin
            ax = xs;
            ay = ys;
            bx = xe;
            by = ye;
            dx = (bx > ax) ? bx - ax : ax - bx;
            dy = (by > ay) ? by - ay : ay - by;
            if (dx >= dy) begin
               y_major     = 1'b0;
               major_delta = dx[11:0];
               minor_delta = dy[11:0];
               if (ax > bx) begin
                  cur_x = xe; cur_y = ye; major_end = xs; minor_end = ys;
               end else begin
                  cur_x = xs; cur_y = ys; major_end = xe; minor_end = ye;
               end
               fin = (cur_x == major_end);
            end else begin
               y_major     = 1'b1;
               major_delta = dy[11:0];
               minor_delta = dx[11:0];
               if (ay < by) begin
                  cur_x = xs; cur_y = ys; major_end = ye; minor_end = xe;
               end else begin
                  cur_x = xe; cur_y = ye; major_end = ys; minor_end = xs;
               end
               fin = (cur_y == major_end);
            end
            d        = 2 * int'(minor_delta) - int'(major_delta);
            decision = d[14:0];
         end else begin
            if (!active)
               return 0;
            mj = y_major ? int'(cur_y) : int'(cur_x);
            mn = y_major ? int'(cur_x) : int'(cur_y);
            mj = int'(coord_type'(mj + 1));
            d  = decision;
            if (d < 0) begin
               d = d + 2 * int'(minor_delta);
            end else begin
               if (mn < int'(minor_end))
                  mn = int'(coord_type'(mn + 1));
               else
                  mn = int'(coord_type'(mn - 1));
               d = d + 2 * int'(minor_delta) - 2 * int'(major_delta);
            end
            decision = d[14:0];
            if (y_major) begin
               cur_y = coord_type'(mj);
               cur_x = coord_type'(mn);
            end else begin
               cur_x = coord_type'(mj);
               cur_y = coord_type'(mn);
            end
            fin = (coord_type'(mj) == major_end);
         end
         active  = !fin;
         px.x    = cur_x;
         px.y    = cur_y;
         px.last = fin;
         pending.push_back(px);
         return 1;
      endfunction

      function void check_pixel(coord_type x, coord_type y, logic last);
         pixel_type px;
         if (pending.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time, x, y, last);
            errors++;
            return;
         end
         px = pending.pop_front();
         if (x !== px.x) begin
            $display("%0t: pixel_x expected %0d actual %0d", $time, px.x, x);
            errors++;
         end
         if (y !== px.y) begin
            $display("%0t: pixel_y expected %0d actual %0d", $time, px.y, y);
            errors++;
         end
         if (last !== px.last) begin
            $display("%0t: last expected %0b actual %0b", $time, px.last, last);
            errors++;
         end
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      push  = 1'b0;
   logic      pop   = 1'b0;
   logic      full;
   logic      empty;
   logic      req_op      = OP_START;
   coord_type req_x_start = '0;
   coord_type req_y_start = '0;
   coord_type req_x_end   = '0;
   coord_type req_y_end   = '0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   logic      rsp_last;

   int tx_idle_pct = 9;
   int rx_idle_pct = 80;
   int pixel_words = 0;

   pixel_scoreboard sb = new();

   bresenham_line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_op      (req_op),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .empty       (empty),
      .pop         (pop),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_last);
   end

   function automatic coord_type rand_coord();
      return coord_type'(int'($urandom_range(2047)) - 1024);
   endfunction

   function automatic coord_type clamp_coord(int v);
      if (v > 1023)
         v = 1023;
      if (v < -1024)
         v = -1024;
      return coord_type'(v);
   endfunction

   task automatic send_word(logic op, coord_type xs, coord_type ys, coord_type xe,
                            coord_type ye);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_op      <= op;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end   <= xe;
      req_y_end   <= ye;
      @(posedge clock);
      while (full)
         @(posedge clock);
      if (sb.note_request(op, xs, ys, xe, ye))
         pixel_words++;
   endtask

   task automatic send_steps(int n);
      repeat (n)
         send_word(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   initial begin
      int        len, dx, dy, nsteps, wait_cycles, pick;
      coord_type ax, ay, bx, by;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      send_steps(1);
      send_word(OP_START, coord_type'(0), coord_type'(0), coord_type'(0), coord_type'(0));
      send_steps(1);
      send_word(OP_START, coord_type'(-1024), coord_type'(-1024),
                coord_type'(1023), coord_type'(1023));
      send_steps(3);
      send_word(OP_START, coord_type'(1023), coord_type'(-1024),
                coord_type'(-1024), coord_type'(1023));
      send_steps(2);
      send_word(OP_START, coord_type'(-1024), coord_type'(1023),
                coord_type'(-1024), coord_type'(-1024));
      send_steps(2);
      send_word(OP_START, coord_type'(5), coord_type'(-7), coord_type'(3), coord_type'(9));
      send_steps(3);
      send_word(OP_START, coord_type'(3), coord_type'(2), coord_type'(-2), coord_type'(5));
      send_steps(6);
      send_word(OP_START, coord_type'(1023), coord_type'(1023),
                coord_type'(1023), coord_type'(1023));

      while (pixel_words < LINE_WORDS) begin
         if (pixel_words >= 2 * LINE_WORDS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (pixel_words >= LINE_WORDS / 3) begin
            tx_idle_pct = 80;
            rx_idle_pct = 9;
         end
         if ($urandom_range(99) < 85) begin
            ax = rand_coord();
            ay = rand_coord();
            if ($urandom_range(99) < 5) begin
               bx = rand_coord();
               by = rand_coord();
            end else begin
               bx = clamp_coord(int'(ax) + int'($urandom_range(40)) - 20);
               by = clamp_coord(int'(ay) + int'($urandom_range(40)) - 20);
            end
            send_word(OP_START, ax, ay, bx, by);
            dx   = (bx > ax) ? int'(bx) - int'(ax) : int'(ax) - int'(bx);
            dy   = (by > ay) ? int'(by) - int'(ay) : int'(ay) - int'(by);
            len  = (dx >= dy) ? dx : dy;
            pick = int'($urandom_range(99));
            if (pick < 70)
               nsteps = len;
            else if (pick < 85)
               nsteps = len + int'($urandom_range(1, 3));
            else
               nsteps = int'($urandom_range(len));
            if (nsteps > 40)
               nsteps = int'($urandom_range(40));
            send_steps(nsteps);
         end else begin
            send_word(logic'($urandom_range(1)), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());
         end
      end

      @(negedge clock);
      push <= 1'b0;

      wait_cycles = 0;
      while (sb.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $display("%0t: %0d pixels never arrived", $time, sb.pending.size());
         sb.errors++;
      end

      if (sb.errors == 0)
         $display("bresenham_line_rasterizer verification clean");
      else
         $display("bresenham_line_rasterizer verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("bresenham_line_rasterizer verification failed");
      $finish;
   end

endmodule
